// ===== design/tip_pkg.sv =====
// Shared constants and controller-to-datapath command type for the interval profiler.
package tip_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TAG_W     = 16;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int STAT_W    = 32;

  localparam logic [STAT_W-1:0] STAT_ONES = {STAT_W{1'b1}};

  // One pulse per step of an item's read-modify-write.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic match;    // register per-slot match and free vectors
    logic read;     // pick the slot, start the stats read
    logic load;     // update the slot and load the result register
  } tip_cmd_t;

endpackage

// ===== design/tip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tip_ctrl.sv =====
// Sequencer for the profiler: steps each item through match, read and update.
module tip_ctrl
  import tip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output tip_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CALC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  // result register can take a new item when empty or being drained
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = in_valid && !in_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_MATCH)
    else $error("accepted item did not enter match step");
  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_IDLE && out_valid)
    else $error("update step did not present a result");
  a_rise_after_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_CALC)
    else $error("result appeared without an update step");
`endif

endmodule

// ===== design/tip_dp.sv =====
// Datapath: tag table, slot select, stats RAM and result register.
module tip_dp
  import tip_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tip_cmd_t          cmd,
  input  logic [TAG_W-1:0]  tag_id,
  input  logic [TIME_W-1:0] now,
  output logic              table_full,
  output logic [SLOT_W-1:0] slot,
  output logic [STAT_W-1:0] interval,
  output logic [STAT_W-1:0] total,
  output logic [STAT_W-1:0] shortest,
  output logic [STAT_W-1:0] longest,
  output logic [STAT_W-1:0] hits
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WORD_W = 4 * STAT_W;

  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] last_time;
  logic [TAG_W-1:0]  slot_tag [SLOTS];
  logic [SLOTS-1:0]  slot_used;
  logic [SLOTS-1:0]  hit_vec;
  logic [SLOTS-1:0]  free_vec;

  logic              hit_any;
  logic              free_any;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  sel_idx;
  logic [IDX_W-1:0]  idx_r;
  logic              hit_r;
  logic              full_r;
  logic [IDX_W+3:0]  idx_ext;

  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;
  logic              we;
  logic [STAT_W-1:0] old_total, old_short, old_long, old_hits;
  logic [STAT_W-1:0] gap, new_total, new_short, new_long, new_hits;

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(k);
      end
      if (free_vec[k]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
  end

  assign sel_idx = hit_any ? hit_idx : free_idx;

  // a freshly claimed slot starts from the reset stats
  assign old_total = hit_r ? rdata[4*STAT_W-1:3*STAT_W] : '0;
  assign old_short = hit_r ? rdata[3*STAT_W-1:2*STAT_W] : STAT_ONES;
  assign old_long  = hit_r ? rdata[2*STAT_W-1:STAT_W]   : '0;
  assign old_hits  = hit_r ? rdata[STAT_W-1:0]          : '0;

  assign gap       = now_r - last_time;
  assign new_total = old_total + gap;
  assign new_short = (gap < old_short) ? gap : old_short;
  assign new_long  = (gap > old_long) ? gap : old_long;
  assign new_hits  = old_hits + STAT_W'(1);

  assign we      = cmd.load && !full_r;
  assign wdata   = {new_total, new_short, new_long, new_hits};
  assign idx_ext = {4'b0000, idx_r};

  tip_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_stats (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (sel_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_r <= tag_id;
      now_r <= now;
    end
    if (cmd.match) begin
      for (int k = 0; k < SLOTS; k++) begin
        hit_vec[k]  <= slot_used[k] && (slot_tag[k] == tag_r);
        free_vec[k] <= !slot_used[k];
      end
    end
    if (cmd.read) begin
      idx_r  <= sel_idx;
      hit_r  <= hit_any;
      full_r <= !hit_any && !free_any;
    end
    if (we) begin
      slot_tag[idx_r] <= tag_r;
    end
    if (cmd.load) begin
      table_full <= full_r;
      slot       <= full_r ? '0 : idx_ext[3:0];
      interval   <= full_r ? '0 : gap;
      total      <= full_r ? '0 : new_total;
      shortest   <= full_r ? '0 : new_short;
      longest    <= full_r ? '0 : new_long;
      hits       <= full_r ? '0 : new_hits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      last_time <= '0;
    end else if (we) begin
      slot_used[idx_r] <= 1'b1;
      last_time        <= now_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_hit_slot_used: assert property (@(posedge clk) disable iff (rst)
    cmd.read && hit_any |=> slot_used[idx_r])
    else $error("matched slot is not in use");
  a_full_keeps_time: assert property (@(posedge clk) disable iff (rst)
    cmd.load && full_r |=> last_time == $past(last_time))
    else $error("full table changed the last timestamp");
  a_claim_unused: assert property (@(posedge clk) disable iff (rst)
    cmd.read && !hit_any && free_any |=> !slot_used[idx_r])
    else $error("claimed slot was already in use");
`endif

endmodule

// ===== design/tagged_interval_profiler.sv =====
// Top level of the tagged interval profiler: sequencer plus datapath.
// An accepted item steps through match, select/read and update; the update step loads the result register.
// A new item is taken only once the last one is through; the stats RAM read-modify-write sets the pace.
// Input stall stays high from acceptance until the update step loads the result register.
// A result left waiting on a stalled output holds the next item in its update step.
// Reset (rst, synchronous) empties the table at once through per-slot used flags; no sweep.
module tagged_interval_profiler
  import tip_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TAG_W-1:0]  tag_id,
  input  logic [TIME_W-1:0] now,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              table_full,
  output logic [SLOT_W-1:0] slot,
  output logic [STAT_W-1:0] interval,
  output logic [STAT_W-1:0] total,
  output logic [STAT_W-1:0] shortest,
  output logic [STAT_W-1:0] longest,
  output logic [STAT_W-1:0] hits
);

  // one command pulse per step of the item's update
  tip_cmd_t cmd;

  tip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // tag table compare, lowest-slot select, stats RAM and the result register
  tip_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .tag_id     (tag_id),
    .now        (now),
    .table_full (table_full),
    .slot       (slot),
    .interval   (interval),
    .total      (total),
    .shortest   (shortest),
    .longest    (longest),
    .hits       (hits)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the tagged interval profiler.
module testbench;
  import tip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Directed rows either carry a hand-written result or defer to the predictor.
  localparam bit KNOWN   = 1'b1;
  localparam bit PREDICT = 1'b0;

  // Items in the random part, and when the long output hold-off kicks in.
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 300;

  // Watchdog: cycles in a row with no item moving on either side.
  // Worst case is the long hold-off plus a few item times, so this is generous.
  localparam int IDLE_LIMIT = 4000;

  // Cycles to linger after the last result before the run ends.
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic              full;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] interval;
    logic [STAT_W-1:0] total;
    logic [STAT_W-1:0] shortest;
    logic [STAT_W-1:0] longest;
    logic [STAT_W-1:0] hits;
  } stats_t;

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    bit                typed;
    stats_t            want;
  } stim_row_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_BEAT, STALL_RARE} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TAG_W-1:0]  tag_id = '0;
  logic [TIME_W-1:0] now = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              table_full;
  logic [SLOT_W-1:0] slot;
  logic [STAT_W-1:0] interval;
  logic [STAT_W-1:0] total;
  logic [STAT_W-1:0] shortest;
  logic [STAT_W-1:0] longest;
  logic [STAT_W-1:0] hits;

  // Predictor's private copy of the slot table.
  logic [TAG_W-1:0]  prof_tag   [SLOTS_DEF];
  logic              prof_used  [SLOTS_DEF];
  logic [STAT_W-1:0] prof_total [SLOTS_DEF];
  logic [STAT_W-1:0] prof_min   [SLOTS_DEF];
  logic [STAT_W-1:0] prof_max   [SLOTS_DEF];
  logic [STAT_W-1:0] prof_hits  [SLOTS_DEF];
  logic [TIME_W-1:0] prof_last;

  stats_t      stats_due[$];   // results owed by the block, oldest first
  stim_row_t   dir_rows[$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_cyc = 0;
  int          hold_left = 0;
  bit          held = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;

  tagged_interval_profiler dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .tag_id     (tag_id),
    .now        (now),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .table_full (table_full),
    .slot       (slot),
    .interval   (interval),
    .total      (total),
    .shortest   (shortest),
    .longest    (longest),
    .hits       (hits)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bit-exact model of one event: find the tag (lowest used slot wins), else
  // claim the lowest free slot, else report a full table and touch nothing.
  function automatic stats_t profile_event(input logic [TAG_W-1:0] t,
                                           input logic [TIME_W-1:0] stamp);
    stats_t            r = '0;
    int                hit = -1;
    int                spare = -1;
    logic [STAT_W-1:0] gap;
    for (int k = 0; k < SLOTS_DEF; k++) begin
      if (hit < 0) begin
        if (prof_used[k]) begin
          if (prof_tag[k] == t) hit = k;
        end else if (spare < 0) begin
          spare = k;
        end
      end
    end
    if (hit < 0) hit = spare;
    if (hit < 0) begin
      r.full = 1'b1;
      return r;
    end
    gap = stamp - prof_last;  // wraps mod 2^32
    prof_total[hit] = prof_total[hit] + gap;
    if (gap < prof_min[hit]) prof_min[hit] = gap;
    if (gap > prof_max[hit]) prof_max[hit] = gap;
    prof_tag[hit]  = t;
    prof_used[hit] = 1'b1;
    prof_hits[hit] = prof_hits[hit] + STAT_W'(1);
    prof_last      = stamp;
    r.slot     = hit[SLOT_W-1:0];
    r.interval = gap;
    r.total    = prof_total[hit];
    r.shortest = prof_min[hit];
    r.longest  = prof_max[hit];
    r.hits     = prof_hits[hit];
    return r;
  endfunction

  task automatic add_row(input logic [TAG_W-1:0] t, input logic [TIME_W-1:0] stamp,
                         input bit typed, input logic full, input logic [SLOT_W-1:0] s,
                         input logic [STAT_W-1:0] iv, input logic [STAT_W-1:0] tot,
                         input logic [STAT_W-1:0] lo, input logic [STAT_W-1:0] hi,
                         input logic [STAT_W-1:0] cnt);
    stim_row_t row;
    row.tag   = t;
    row.stamp = stamp;
    row.typed = typed;
    row.want  = '{full, s, iv, tot, lo, hi, cnt};
    dir_rows.push_back(row);
  endtask

  // Offer one item, holding it steady until accepted. Gaps only open between
  // bursts; valid is lowered only when a real gap follows, never pulsed.
  task automatic send_item(input logic [TAG_W-1:0] t, input logic [TIME_W-1:0] stamp,
                           input bit typed, input stats_t want);
    int     gap;
    stats_t calc;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    tag_id   <= t;
    now      <= stamp;
    do @(posedge clk); while (in_stall);
    // Accepted at this edge: the predictor always advances, typed rows
    // override what gets checked.
    calc = profile_event(t, stamp);
    stats_due.push_back(typed ? want : calc);
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                             input logic [STAT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Receiver: stalls follow a pattern that is redrawn at random; once, after enough
  // items have gone in, it holds off long enough to back the block up.
  always @(posedge clk) begin
    stall_cyc++;
    if (!held && items_sent >= HOLD_AFTER) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_cyc % 96 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
        STALL_BEAT: out_stall <= (stall_cyc % 5 < 2);
        default:    out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker: every accepted result must match the oldest expectation.
  always @(posedge clk) begin : result_check
    stats_t want;
    if (!rst && out_valid && !out_stall) begin
      if (stats_due.size() == 0) begin
        errors++;
        $display("%0t ns unexpected result: expected none, got slot %h", $time, slot);
      end else begin
        want = stats_due.pop_front();
        check_field("table_full", STAT_W'(want.full), STAT_W'(table_full));
        check_field("slot", STAT_W'(want.slot), STAT_W'(slot));
        check_field("interval", want.interval, interval);
        check_field("total", want.total, total);
        check_field("shortest", want.shortest, shortest);
        check_field("longest", want.longest, longest);
        check_field("hits", want.hits, hits);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [TAG_W-1:0]  t;
    logic [TIME_W-1:0] stamp;
    stats_t            none;
    none = '0;
    for (int k = 0; k < SLOTS_DEF; k++) begin
      prof_tag[k]   = '0;
      prof_used[k]  = 1'b0;
      prof_total[k] = '0;
      prof_min[k]   = STAT_ONES;  // first interval replaces this unless it is all ones too
      prof_max[k]   = '0;
      prof_hits[k]  = '0;
    end
    prof_last = '0;

    // Directed table.
    // Fresh table, last time is zero: tag 0 lands in slot 0 with a zero interval.
    add_row(16'h0000, 32'h0000_0000, KNOWN, 1'b0, 4'd0,
            32'h0, 32'h0, 32'h0, 32'h0, 32'd1);
    // Top tag, top time: full-scale interval; all-ones minimum stays all ones.
    add_row(16'hFFFF, 32'hFFFF_FFFF, KNOWN, 1'b0, 4'd1,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    // Timer wrap: 0 - all ones = 1, and the total wraps to zero.
    add_row(16'hFFFF, 32'h0000_0000, KNOWN, 1'b0, 4'd1,
            32'd1, 32'h0, 32'd1, 32'hFFFF_FFFF, 32'd2);
    // Back to slot 0: minimum holds at zero, maximum grows.
    add_row(16'h0000, 32'd5, KNOWN, 1'b0, 4'd0,
            32'd5, 32'd5, 32'h0, 32'd5, 32'd2);
    // Claim the remaining slots in order, up to slot 15.
    for (int i = 1; i < SLOTS_DEF - 1; i++)
      add_row(i[TAG_W-1:0], TIME_W'(1000 * i), PREDICT, 1'b0, '0, '0, '0, '0, '0, '0);
    // Table full: new tags are refused with every other field zero.
    add_row(16'h1234, 32'h8000_0000, KNOWN, 1'b1, '0, '0, '0, '0, '0, '0);
    add_row(16'h8000, 32'd7, KNOWN, 1'b1, '0, '0, '0, '0, '0, '0);
    // A refused item must not move the last timestamp.
    add_row(16'd7, 32'd14050, PREDICT, 1'b0, '0, '0, '0, '0, '0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].tag, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].want);

    // Random part: the table is full now, so most items hit a known tag and
    // stress the statistics; the rest are stray tags that bounce off.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 4) != 0)
        t = prof_tag[$urandom_range(0, SLOTS_DEF - 1)];
      else
        t = TAG_W'($urandom_range(0, 16'hFFFF));
      case ($urandom_range(0, 7))
        0, 1, 2, 3: stamp = prof_last + $urandom_range(0, 500);
        4, 5:       stamp = prof_last + $urandom_range(0, 32'h00FF_FFFF);
        6:          stamp = $urandom;
        default:    stamp = prof_last - $urandom_range(0, 500);  // near-full wrap
      endcase
      send_item(t, stamp, PREDICT, none);
    end
    in_valid <= 1'b0;

    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && stats_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
